[hdl/hcm_pkg.sv]
// shared constants and types of the height to color map unit
package hcm_pkg;

	// default widths of the height samples and of the normalized fraction
	localparam int HEIGHT_BITS_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 16;

	// configuration port
	localparam int CFG_ADDR_BITS = 2;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_HEIGHT_MIN = 2'd0,
		REG_HEIGHT_MAX = 2'd1,
		REG_COLOR_MODE = 2'd2
	} cfg_reg_t;

	// pixel layout: red, green, blue bytes from the lowest bit up
	localparam int CHAN_BITS  = 8;
	localparam int CHANNELS   = 3;
	localparam int PIXEL_BITS = CHAN_BITS * CHANNELS;

	// knot levels of the colormap, bit i is knot i (red, yellow, green, cyan, blue)
	localparam int KNOT_COUNT = 5;
	localparam logic [KNOT_COUNT-1:0] KNOTS [CHANNELS] = '{
		5'b00011,   // red
		5'b01110,   // green
		5'b11000    // blue
	};

	// side information that travels with each request down the pipeline
	typedef struct packed {
		logic blank;   // empty or inverted range, pixel is black
		logic mode;    // 0 grayscale, 1 colormap
		logic last;    // end of frame
	} side_t;

endpackage

[hdl/hcm_prep.sv]
// front stages: range difference, distance to the reference end, clamping
module hcm_prep
	import hcm_pkg::*;
#(
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  logic [HEIGHT_BITS-1:0] height,
	input  logic                   last,
	input  logic [HEIGHT_BITS-1:0] cfg_min,
	input  logic [HEIGHT_BITS-1:0] cfg_max,
	input  logic                   cfg_mode,
	output logic                   out_valid,
	output side_t                  out_side,
	output logic [HEIGHT_BITS-1:0] out_num,
	output logic [HEIGHT_BITS-1:0] out_den
);

	logic signed [HEIGHT_BITS:0] lo_x, hi_x, z_x, den_x, dist_x;
	logic                        valid_s1, valid_s2;
	side_t                       side_s1, side_s2;
	logic signed [HEIGHT_BITS:0] den_s1, dist_s1;
	logic [HEIGHT_BITS-1:0]      den_s2, num_s2, num_x;

	// sign extend by one bit so the differences cannot overflow
	assign lo_x   = $signed({cfg_min[HEIGHT_BITS-1], cfg_min});
	assign hi_x   = $signed({cfg_max[HEIGHT_BITS-1], cfg_max});
	assign z_x    = $signed({height[HEIGHT_BITS-1], height});
	assign den_x  = hi_x - lo_x;
	assign dist_x = cfg_mode ? (hi_x - z_x) : (z_x - lo_x);

	// clamp the distance into [0, den]
	always_comb begin
		if (dist_s1[HEIGHT_BITS]) begin
			num_x = '0;
		end else if (dist_s1 > den_s1) begin
			num_x = den_s1[HEIGHT_BITS-1:0];
		end else begin
			num_x = dist_s1[HEIGHT_BITS-1:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.blank <= !(hi_x > lo_x);
			side_s1.mode  <= cfg_mode;
			side_s1.last  <= last;
			den_s1        <= den_x;
			dist_s1       <= dist_x;
			side_s2       <= side_s1;
			den_s2        <= den_s1[HEIGHT_BITS-1:0];
			num_s2        <= num_x;
		end
	end

	assign out_valid = valid_s2;
	assign out_side  = side_s2;
	assign out_num   = num_s2;
	assign out_den   = den_s2;

endmodule

[hdl/hcm_div.sv]
// pipelined restoring divider, one quotient bit per stage: floor(num * 2^F / den)
module hcm_div
	import hcm_pkg::*;
#(
	parameter int HEIGHT_BITS   = HEIGHT_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  side_t                    in_side,
	input  logic [HEIGHT_BITS-1:0]   num,
	input  logic [HEIGHT_BITS-1:0]   den,
	output logic                     out_valid,
	output side_t                    out_side,
	output logic [FRACTION_BITS:0]   quo
);

	localparam int STAGES = FRACTION_BITS + 1;

	logic                   valid_s [STAGES];
	side_t                  side_s  [STAGES];
	logic [FRACTION_BITS:0] quo_s   [STAGES];
	logic [HEIGHT_BITS-1:0] rem_s   [STAGES-1];
	logic [HEIGHT_BITS-1:0] den_s   [STAGES-1];

	// first stage: num <= den, so the integer bit is num == den
	logic                   bit0;
	logic [HEIGHT_BITS-1:0] rem0;

	assign bit0 = (num >= den);
	assign rem0 = bit0 ? (num - den) : num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= in_side;
			quo_s[0]  <= {{FRACTION_BITS{1'b0}}, bit0};
			rem_s[0]  <= rem0;
			den_s[0]  <= den;
		end
	end

	// fraction stages: shift in a zero, compare and subtract
	for (genvar k = 1; k < STAGES; k++) begin : g_stage
		logic [HEIGHT_BITS:0]   shifted;
		logic                   qbit;
		logic [HEIGHT_BITS:0]   diff;

		assign shifted = {rem_s[k-1], 1'b0};
		assign qbit    = (shifted >= {1'b0, den_s[k-1]});
		assign diff    = shifted - {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
				quo_s[k]  <= {quo_s[k-1][FRACTION_BITS-1:0], qbit};
			end
		end

		// the remainder stays below den, so it fits back into the height width
		if (k < STAGES - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k] <= qbit ? diff[HEIGHT_BITS-1:0] : shifted[HEIGHT_BITS-1:0];
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign out_valid = valid_s[STAGES-1];
	assign out_side  = side_s[STAGES-1];
	assign quo       = quo_s[STAGES-1];

endmodule

[hdl/hcm_shade.sv]
// color stages: knot interpolation or gray level, then scaling to bytes
module hcm_shade
	import hcm_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  side_t                  in_side,
	input  logic [FRACTION_BITS:0] quo,
	output logic                   out_valid,
	output logic                   out_last,
	output logic [CHAN_BITS-1:0]   red,
	output logic [CHAN_BITS-1:0]   green,
	output logic [CHAN_BITS-1:0]   blue
);

	localparam int SEG_BITS = $clog2(KNOT_COUNT - 1);

	logic [SEG_BITS-1:0]    seg;
	logic [SEG_BITS:0]      seg_next;
	logic [FRACTION_BITS:0] rem;
	logic [FRACTION_BITS:0] one;
	logic [FRACTION_BITS:0] chan_x  [CHANNELS];
	logic [FRACTION_BITS:0] chan_s1 [CHANNELS];
	logic [CHAN_BITS-1:0]   byte_s2 [CHANNELS];
	logic [FRACTION_BITS+CHAN_BITS:0] scaled [CHANNELS];
	logic                   valid_s1, valid_s2, last_s1, last_s2;

	assign one = {1'b1, {FRACTION_BITS{1'b0}}};

	// segment and remainder of 4 * q; q equal to one lands at the end of the last segment
	always_comb begin
		if (quo[FRACTION_BITS]) begin
			seg = SEG_BITS'(KNOT_COUNT - 2);
			rem = one;
		end else begin
			seg = quo[FRACTION_BITS-1 -: SEG_BITS];
			rem = {1'b0, quo[FRACTION_BITS-SEG_BITS-1:0], {SEG_BITS{1'b0}}};
		end
		seg_next = {1'b0, seg} + 1'b1;
	end

	// channel fractions per knot pair
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			logic here, next;
			here = KNOTS[ch][seg];
			next = KNOTS[ch][seg_next];
			if (in_side.blank) begin
				chan_x[ch] = '0;
			end else if (!in_side.mode) begin
				chan_x[ch] = quo;
			end else if (next && !here) begin
				chan_x[ch] = rem;
			end else if (here && !next) begin
				chan_x[ch] = one - rem;
			end else if (here) begin
				chan_x[ch] = one;
			end else begin
				chan_x[ch] = '0;
			end
		end
	end

	// byte = floor(255 * c / 2^F), with 255 * c as a shift and a subtract
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			scaled[ch] = {chan_s1[ch], {CHAN_BITS{1'b0}}} - {{CHAN_BITS{1'b0}}, chan_s1[ch]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= in_side.last;
			last_s2 <= last_s1;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				chan_s1[ch] <= chan_x[ch];
				byte_s2[ch] <= scaled[ch][FRACTION_BITS+CHAN_BITS-1:FRACTION_BITS];
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_last  = last_s2;
	assign red       = byte_s2[0];
	assign green     = byte_s2[1];
	assign blue      = byte_s2[2];

endmodule

[hdl/hcm_skid.sv]
// output register with one skid entry; stalls the pipeline only when the skid is full
module hcm_skid
	import hcm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [PIXEL_BITS-1:0] in_data,
	input  logic                  in_last,
	output logic                  adv,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIXEL_BITS-1:0] m_tdata,
	output logic                  m_tlast
);

	logic                  out_valid_q, skid_valid_q;
	logic [PIXEL_BITS:0]   out_q, skid_q;
	logic                  take, push;

	assign adv  = !skid_valid_q;
	assign push = in_valid && !skid_valid_q;
	assign take = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// the skid entry drains first, it holds the older request
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= {in_last, in_data};
			end
		end else if (push) begin
			skid_q <= {in_last, in_data};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q[PIXEL_BITS-1:0];
	assign m_tlast  = out_q[PIXEL_BITS];

endmodule

[hdl/height_to_color_map_unit.sv]
// top level of the height to color map unit
//
// Maps one signed height sample per request to one RGB pixel.
// Input stream: s_tdata carries the height, s_tlast marks the last pixel of a frame.
// Output stream: m_tdata carries red, green, blue bytes, m_tlast copies the frame end.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 minimum height,
// 1 maximum height, 2 color mode); write only while no request is in flight.
// Grayscale mode ramps from the minimum (black) to the maximum (white); colormap
// mode runs red, yellow, green, cyan, blue from the maximum down to the minimum.
// An empty or inverted range gives black pixels.
// Path from input acceptance to m_tvalid: two range stages, FRACTION_BITS + 1
// divider stages, two color stages and the output register. Throughput: one pixel
// per cycle while the receiver keeps m_tready high, set by the one-bit-per-stage
// divider pipeline.
// Reset clears all valid bits and loads minimum 0, maximum the largest positive
// height and grayscale mode. When the receiver stalls, one more pixel parks in a
// skid entry and then s_tready drops until the output drains; nothing is lost.
module height_to_color_map_unit
	import hcm_pkg::*;
#(
	parameter int HEIGHT_BITS   = HEIGHT_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [CFG_ADDR_BITS-1:0]             cfg_addr,
	input  logic [HEIGHT_BITS-1:0]               cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((HEIGHT_BITS+7)/8)*8-1:0]     s_tdata,   // height
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [PIXEL_BITS-1:0]                m_tdata,   // red, green, blue
	output logic                                 m_tlast
);

	logic [HEIGHT_BITS-1:0] height_min_q, height_max_q;
	logic                   color_mode_q;
	logic                   adv;

	logic                   prep_valid;
	side_t                  prep_side;
	logic [HEIGHT_BITS-1:0] prep_num, prep_den;

	logic                   div_valid;
	side_t                  div_side;
	logic [FRACTION_BITS:0] div_quo;

	logic                   shade_valid, shade_last;
	logic [CHAN_BITS-1:0]   shade_red, shade_green, shade_blue;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_min_q <= '0;
			height_max_q <= {1'b0, {(HEIGHT_BITS-1){1'b1}}};
			color_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_HEIGHT_MIN: height_min_q <= cfg_wdata;
				REG_HEIGHT_MAX: height_max_q <= cfg_wdata;
				REG_COLOR_MODE: color_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign s_tready = adv;

	// range and distance
	hcm_prep #(
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_tvalid),
		.height   (s_tdata[HEIGHT_BITS-1:0]),
		.last     (s_tlast),
		.cfg_min  (height_min_q),
		.cfg_max  (height_max_q),
		.cfg_mode (color_mode_q),
		.out_valid(prep_valid),
		.out_side (prep_side),
		.out_num  (prep_num),
		.out_den  (prep_den)
	);

	// normalization
	hcm_div #(
		.HEIGHT_BITS  (HEIGHT_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (prep_valid),
		.in_side  (prep_side),
		.num      (prep_num),
		.den      (prep_den),
		.out_valid(div_valid),
		.out_side (div_side),
		.quo      (div_quo)
	);

	// color
	hcm_shade #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (div_valid),
		.in_side  (div_side),
		.quo      (div_quo),
		.out_valid(shade_valid),
		.out_last (shade_last),
		.red      (shade_red),
		.green    (shade_green),
		.blue     (shade_blue)
	);

	// output buffer
	hcm_skid u_skid (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(shade_valid),
		.in_data ({shade_blue, shade_green, shade_red}),
		.in_last (shade_last),
		.adv     (adv),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

[hdl/hcm_checker.sv]
// port-level checks of the height to color map unit and their binding
module hcm_checker
	import hcm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [PIXEL_BITS-1:0] m_tdata,
	input logic                  m_tlast
);

	// input backpressure only while a pixel is held at the output
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("s_tready low with no pixel at the output");

	// backpressure starts only after the receiver refused a pixel
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("s_tready fell without a refused output pixel");

	// a drained output frees the skid entry at once
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_tready && m_tready) |=> s_tready)
		else $error("s_tready stayed low after the output was taken");

	// a refused pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("output pixel changed while stalled");

	// s_tvalid is part of the port view but carries no rule of its own here
	logic unused_in_valid;
	assign unused_in_valid = s_tvalid;

endmodule

bind height_to_color_map_unit hcm_checker u_hcm_checker (.*);
